// File: rtl/core/rdsnta_pkg.sv
// Shared types and constants for the RDS station name / radio text assembler.
// No dependencies; imported by rdsnta_merge and rds_name_text_assembler_top.
`timescale 1ns / 1ps
`default_nettype none

package rdsnta_pkg;

   // request channel payload layout
   localparam int REQ_TDATA_W = 56;   // b, c, d, read_address, padded to 7 bytes
   localparam int REQ_TUSER_W = 3;    // opcode, read_store
   localparam int RSP_TDATA_W = 16;   // changed, read_char, padded to 2 bytes

   // store organisation: name as 4 rows of 2 chars, text as 16 rows of 4 chars
   localparam int NAME_ROWS   = 4;
   localparam int NAME_ROW_W  = 16;
   localparam int NAME_ADDR_W = 2;
   localparam int TEXT_ROWS   = 16;
   localparam int TEXT_ROW_W  = 32;
   localparam int TEXT_ADDR_W = 4;

   localparam logic [3:0] GT_BASIC = 4'd0;   // group type 0: station name
   localparam logic [3:0] GT_TEXT  = 4'd2;   // group type 2: radio text

   typedef enum logic [1:0] {
      OP_DECODE = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   // outcome of one item, from the merge logic back to the control
   typedef struct packed {
      logic                  name_we;
      logic [NAME_ROW_W-1:0] name_data;
      logic                  text_we;
      logic [TEXT_ROW_W-1:0] text_data;
      logic                  changed;
      logic [7:0]            read_char;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/core/rdsnta_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rdsnta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/rdsnta_merge.sv
// Read-modify logic: merges a group into the rows just read, flags changes,
// selects a read character. Depends on rdsnta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdsnta_merge (
   input  wire logic [1:0]                         opcode,
   input  wire logic [15:0]                        block_b,
   input  wire logic [15:0]                        block_c,
   input  wire logic [15:0]                        block_d,
   input  wire logic                               read_store,
   input  wire logic [5:0]                         read_address,
   input  wire logic [rdsnta_pkg::NAME_ROW_W-1:0]  name_rd,
   input  wire logic                               name_row_valid,
   input  wire logic [rdsnta_pkg::TEXT_ROW_W-1:0]  text_rd,
   input  wire logic                               text_row_valid,
   output rdsnta_pkg::result_type                  result
);

   import rdsnta_pkg::*;

   logic [NAME_ROW_W-1:0] name_old;
   logic [TEXT_ROW_W-1:0] text_old;
   logic                  is_decode;
   logic [3:0]            group_type;
   logic [7:0]            text_byte;
   logic [7:0]            name_byte;

   // a row that was cleared and not written since reads as zero
   assign name_old   = name_row_valid ? name_rd : '0;
   assign text_old   = text_row_valid ? text_rd : '0;
   assign is_decode  = (opcode == OP_DECODE);
   assign group_type = block_b[15:12];

   always_comb begin
      case (read_address[1:0])
         2'd0:    text_byte = text_old[31:24];
         2'd1:    text_byte = text_old[23:16];
         2'd2:    text_byte = text_old[15:8];
         default: text_byte = text_old[7:0];
      endcase
      name_byte = read_address[0] ? name_old[7:0] : name_old[15:8];
   end

   always_comb begin
      result.name_we   = is_decode && (group_type == GT_BASIC);
      result.name_data = block_d;
      result.text_we   = is_decode && (group_type == GT_TEXT);
      if (!block_b[11]) begin
         result.text_data = {block_c, block_d};
      end else if (block_b[0]) begin
         result.text_data = {text_old[31:16], block_d};
      end else begin
         result.text_data = {block_d, text_old[15:0]};
      end
      // unwritten bytes are carried over, so a whole-row compare is exact
      result.changed = (result.name_we && (result.name_data != name_old)) ||
                       (result.text_we && (result.text_data != text_old));
      result.read_char = 8'd0;
      if (opcode == OP_READ) begin
         if (read_store) begin
            result.read_char = text_byte;
         end else if (read_address[5:3] == 3'd0) begin
            result.read_char = name_byte;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/rds_name_text_assembler_top.sv
// RDS station name / radio text assembler, top level: handshake, control, RAMs.
// Depends on rdsnta_pkg, rdsnta_ram and rdsnta_merge.
//
// Usage:
//   req_* carries one item per beat: a decode of blocks B/C/D, a clear of both
//   stores, or a read of one stored character. rsp_* returns exactly one beat
//   per item: changed flag and read character.
//   Each item has an accept step and an execute step: the accept edge issues
//   a RAM row read, the execute edge merges, writes the row back and loads the
//   response register, once any earlier response is taken. A new item is only
//   accepted after the current one executes, set by the RAM read-then-write.
//   A response waiting in the output register does not block acceptance of
//   the next item; its execute step then waits until the response is taken.
//   The stores live in two RAMs (name 4 x 16 bits, text 16 x 32 bits). Each
//   row has a valid flag; reset and a clear item drop all flags at once, and
//   an invalid row reads as zero, so no clearing pass is needed.
//   Reset is synchronous, active high, and empties the response register.
`timescale 1ns / 1ps
`default_nettype none

module rds_name_text_assembler_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [15:0] block_b, [31:16] block_c, [47:32] block_d, [53:48] read_address
   input  wire logic [rdsnta_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [1:0] opcode, [2] read_store
   input  wire logic [rdsnta_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [0] changed, [8:1] read_char
   output logic      [rdsnta_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   import rdsnta_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type             state_ff, state_in;
   logic [1:0]            op_ff;
   logic [15:0]           b_ff, c_ff, d_ff;
   logic                  store_ff;
   logic [5:0]            addr_ff;
   logic [NAME_ADDR_W-1:0] name_row_ff;
   logic [TEXT_ADDR_W-1:0] text_row_ff;
   logic [NAME_ROWS-1:0]  name_valid_ff, name_valid_in;
   logic [TEXT_ROWS-1:0]  text_valid_ff, text_valid_in;
   logic                  rsp_valid_ff;
   logic                  rsp_changed_ff;
   logic [7:0]            rsp_char_ff;

   logic                  req_fire;
   logic                  exec_fire;
   logic [NAME_ADDR_W-1:0] name_rd_addr;
   logic [TEXT_ADDR_W-1:0] text_rd_addr;
   logic [NAME_ROW_W-1:0] name_rd_data;
   logic [TEXT_ROW_W-1:0] text_rd_data;
   logic                  name_wr_en;
   logic                  text_wr_en;
   result_type            result;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign exec_fire  = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign name_wr_en = exec_fire && result.name_we;
   assign text_wr_en = exec_fire && result.text_we;

   // row to fetch for the incoming item
   always_comb begin
      if (req_tuser[1:0] == OP_DECODE) begin
         name_rd_addr = req_tdata[1:0];
         text_rd_addr = req_tdata[11] ? {1'b0, req_tdata[3:1]} : req_tdata[3:0];
      end else begin
         name_rd_addr = req_tdata[50:49];
         text_rd_addr = req_tdata[53:50];
      end
   end

   rdsnta_ram #(
      .WIDTH (NAME_ROW_W),
      .DEPTH (NAME_ROWS)
   ) u_name_ram (
      .clock   (clock),
      .wr_en   (name_wr_en),
      .wr_addr (name_row_ff),
      .wr_data (result.name_data),
      .rd_en   (req_fire),
      .rd_addr (name_rd_addr),
      .rd_data (name_rd_data)
   );

   rdsnta_ram #(
      .WIDTH (TEXT_ROW_W),
      .DEPTH (TEXT_ROWS)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (text_wr_en),
      .wr_addr (text_row_ff),
      .wr_data (result.text_data),
      .rd_en   (req_fire),
      .rd_addr (text_rd_addr),
      .rd_data (text_rd_data)
   );

   rdsnta_merge u_merge (
      .opcode         (op_ff),
      .block_b        (b_ff),
      .block_c        (c_ff),
      .block_d        (d_ff),
      .read_store     (store_ff),
      .read_address   (addr_ff),
      .name_rd        (name_rd_data),
      .name_row_valid (name_valid_ff[name_row_ff]),
      .text_rd        (text_rd_data),
      .text_row_valid (text_valid_ff[text_row_ff]),
      .result         (result)
   );

   always_comb begin
      state_in      = state_ff;
      name_valid_in = name_valid_ff;
      text_valid_in = text_valid_ff;
      if (req_fire) begin
         state_in = S_EXEC;
      end
      if (exec_fire) begin
         state_in = S_IDLE;
         if (op_ff == OP_CLEAR) begin
            name_valid_in = '0;
            text_valid_in = '0;
         end
         if (result.name_we) begin
            name_valid_in[name_row_ff] = 1'b1;
         end
         if (result.text_we) begin
            text_valid_in[text_row_ff] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         name_valid_ff <= '0;
         text_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         name_valid_ff <= name_valid_in;
         text_valid_ff <= text_valid_in;
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         op_ff       <= req_tuser[1:0];
         store_ff    <= req_tuser[2];
         b_ff        <= req_tdata[15:0];
         c_ff        <= req_tdata[31:16];
         d_ff        <= req_tdata[47:32];
         addr_ff     <= req_tdata[53:48];
         name_row_ff <= name_rd_addr;
         text_row_ff <= text_rd_addr;
      end
      if (exec_fire) begin
         rsp_changed_ff <= result.changed;
         rsp_char_ff    <= result.read_char;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - 9){1'b0}}, rsp_char_ff, rsp_changed_ff};

`ifndef SYNTH
   // an accepted item always goes on to its execute step
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_EXEC))
      else $error("accepted item did not enter execute");

   // row fetch and write-back never meet in one cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (name_wr_en || text_wr_en) |-> !req_fire)
      else $error("RAM read issued during write-back");

   // a clear leaves every row invalid
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && (op_ff == OP_CLEAR)) |=> ((name_valid_ff == '0) && (text_valid_ff == '0)))
      else $error("rows still valid after clear");

   // only a read item returns a character
   a_char_only_on_read: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && (op_ff != OP_READ)) |=> (rsp_char_ff == 8'd0))
      else $error("character returned for a non-read item");

   // a response is never overwritten before it is taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !exec_fire)
      else $error("pending response overwritten");
`endif

endmodule

`default_nettype wire
